@@ rtl/trpd_pkg.sv @@
package trpd_pkg;

  // Default sizes of the index and sample datapaths
  localparam int unsigned INDEX_BITS_DEF  = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 20;

  // Fixed field widths
  localparam int unsigned THRESH_W   = 20;
  localparam int unsigned MINW_W     = 16;
  localparam int unsigned MAXP_W     = 8;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register reset values
  localparam logic [MINW_W-1:0] MIN_WIDTH_RST = MINW_W'(10);
  localparam logic [MAXP_W-1:0] MAX_PEAKS_RST = MAXP_W'(255);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_MIN_WIDTH = 2'd1,
    CFG_MAX_PEAKS = 2'd2
  } cfg_reg_e;

  // One result transaction
  typedef struct packed {
    logic             peak_valid;
    logic [POS_W-1:0] peak_position;
    logic [CNT_W-1:0] peak_count;
    logic             buffer_done;
  } peak_t;

endpackage

@@ rtl/trpd_sample_if.sv @@
interface trpd_sample_if #(
  parameter int unsigned SAMPLE_BITS = trpd_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

@@ rtl/trpd_peak_if.sv @@
interface trpd_peak_if;
  import trpd_pkg::*;

  logic             valid;
  logic             ready;
  logic             peak_valid;
  logic [POS_W-1:0] peak_position;
  logic [CNT_W-1:0] peak_count;
  logic             buffer_done;

  modport source (output valid, output peak_valid, output peak_position,
                  output peak_count, output buffer_done, input ready);
  modport sink   (input valid, input peak_valid, input peak_position,
                  input peak_count, input buffer_done, output ready);
endinterface

@@ rtl/threshold_region_peak_detector_top.sv @@
// A result enters the output buffer when its sample is accepted, behind any result still queued.
// Throughput: one sample per cycle while the output buffer is not full; region state registers update once per sample.
// A two-entry output buffer keeps samples flowing while one result waits downstream.
// Samples that produce no result never occupy the output buffer.
// Reset (rst_ni low, asynchronous): region state cleared, output buffer empty,
// threshold 0, min_width 10, max_peaks 255.
module threshold_region_peak_detector_top #(
  parameter int unsigned INDEX_BITS  = trpd_pkg::INDEX_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = trpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [trpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [trpd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  trpd_sample_if.sink                      in_i,
  trpd_peak_if.source                      out_o
);
  import trpd_pkg::*;

  localparam int unsigned CMP_W  = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam int unsigned WCMP_W = (INDEX_BITS > MINW_W) ? INDEX_BITS : MINW_W;

  // Configuration registers
  logic [THRESH_W-1:0] threshold_q;
  logic [MINW_W-1:0]   min_width_q;
  logic [MAXP_W-1:0]   max_peaks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      min_width_q <= MIN_WIDTH_RST;
      max_peaks_q <= MAX_PEAKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: threshold_q <= cfg_data_i[THRESH_W-1:0];
        CFG_MIN_WIDTH: min_width_q <= cfg_data_i[MINW_W-1:0];
        CFG_MAX_PEAKS: max_peaks_q <= cfg_data_i[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  // Region tracking state
  logic                   in_region_q, in_region_d;
  logic [INDEX_BITS-1:0]  sample_index_q, sample_index_d;
  logic [INDEX_BITS-1:0]  region_start_q, region_start_d;
  logic [SAMPLE_BITS-1:0] previous_sample_q, previous_sample_d;
  logic [INDEX_BITS-1:0]  last_rise_index_q, last_rise_index_d;
  logic [CNT_W-1:0]       peaks_found_q, peaks_found_d;

  logic [1:0] buf_cnt_q, buf_cnt_d;
  peak_t      buf_q [2];

  logic                   accept;
  logic [SAMPLE_BITS-1:0] smp;
  logic                   above, below, rise, wide, room, emit;
  logic [INDEX_BITS-1:0]  width;
  logic [MAXP_W-1:0]      cap;
  logic                   res_valid;
  peak_t                  res;

  assign in_i.ready = (buf_cnt_q != 2'd2);
  assign accept     = in_i.valid && in_i.ready;
  assign smp        = in_i.sample;

  // Compares for region open/close, rise, width and peak capacity
  assign above = CMP_W'(smp) > CMP_W'(threshold_q);
  assign below = CMP_W'(smp) < CMP_W'(threshold_q);
  assign rise  = smp > previous_sample_q;
  assign width = sample_index_q - region_start_q;
  assign wide  = WCMP_W'(width) > WCMP_W'(min_width_q);
  assign cap   = (max_peaks_q == '0) ? MAXP_W'(1) : max_peaks_q;
  assign room  = CNT_W'(peaks_found_q) < CNT_W'(cap);

  always_comb begin
    in_region_d       = in_region_q;
    region_start_d    = region_start_q;
    last_rise_index_d = last_rise_index_q;
    peaks_found_d     = peaks_found_q;
    emit              = 1'b0;

    if (!in_region_q) begin
      if (above) begin
        in_region_d    = 1'b1;
        region_start_d = sample_index_q;
        if (rise) begin
          last_rise_index_d = sample_index_q;
        end
      end
    end else if (below) begin
      in_region_d = 1'b0;
      if (wide && room) begin
        emit          = 1'b1;
        peaks_found_d = peaks_found_q + CNT_W'(1);
      end
    end else if (rise) begin
      last_rise_index_d = sample_index_q;
    end

    previous_sample_d = smp;
    sample_index_d    = sample_index_q + INDEX_BITS'(1);

    // result, taken before the end-of-buffer clear
    res_valid         = emit || in_i.last_sample;
    res.peak_valid    = emit;
    res.peak_position = emit ? POS_W'(last_rise_index_q) : '0;
    res.peak_count    = peaks_found_d;
    res.buffer_done   = in_i.last_sample;

    // last sample returns the tracker to reset
    if (in_i.last_sample) begin
      in_region_d       = 1'b0;
      sample_index_d    = '0;
      region_start_d    = '0;
      previous_sample_d = '0;
      last_rise_index_d = '0;
      peaks_found_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_region_q       <= 1'b0;
      sample_index_q    <= '0;
      region_start_q    <= '0;
      previous_sample_q <= '0;
      last_rise_index_q <= '0;
      peaks_found_q     <= '0;
    end else if (accept) begin
      in_region_q       <= in_region_d;
      sample_index_q    <= sample_index_d;
      region_start_q    <= region_start_d;
      previous_sample_q <= previous_sample_d;
      last_rise_index_q <= last_rise_index_d;
      peaks_found_q     <= peaks_found_d;
    end
  end

  // Two-entry output buffer, head in entry 0
  logic push, pop;

  assign push = accept && res_valid;
  assign pop  = out_o.valid && out_o.ready;

  always_comb begin
    buf_cnt_d = buf_cnt_q;
    if (push && !pop) begin
      buf_cnt_d = buf_cnt_q + 2'd1;
    end else if (pop && !push) begin
      buf_cnt_d = buf_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q <= '0;
    end else begin
      buf_cnt_q <= buf_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      buf_q[0] <= buf_q[1];
      if (push) begin
        if (buf_cnt_q == 2'd1) begin
          buf_q[0] <= res;
        end else begin
          buf_q[1] <= res;
        end
      end
    end else if (push) begin
      buf_q[buf_cnt_q[0]] <= res;
    end
  end

  assign out_o.valid         = (buf_cnt_q != 2'd0);
  assign out_o.peak_valid    = buf_q[0].peak_valid;
  assign out_o.peak_position = buf_q[0].peak_position;
  assign out_o.peak_count    = buf_q[0].peak_count;
  assign out_o.buffer_done   = buf_q[0].buffer_done;

endmodule

@@ tb/threshold_region_peak_detector_top_tb.sv @@
module threshold_region_peak_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trpd_pkg::*;

  localparam int unsigned IDX_W      = INDEX_BITS_DEF;
  localparam int unsigned SMP_W      = SAMPLE_BITS_DEF;
  localparam int unsigned SMP_MAX    = (1 << SMP_W) - 1;
  localparam int unsigned STALL_MAX  = 1000;
  localparam int unsigned HOLD_CYC   = 200;

  typedef struct packed {
    logic [SMP_W-1:0] value;
    logic             is_last;
  } sample_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  trpd_sample_if #(.SAMPLE_BITS(SMP_W)) smp_if ();
  trpd_peak_if                          pk_if ();

  threshold_region_peak_detector_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (smp_if),
    .out_o      (pk_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the configuration registers
  logic [THRESH_W-1:0] thr_reg;
  logic [MINW_W-1:0]   minw_reg;
  logic [MAXP_W-1:0]   maxp_reg;

  // Region tracking state of the detector
  logic             in_reg;
  logic [IDX_W-1:0] smp_idx;
  logic [IDX_W-1:0] reg_start;
  logic [SMP_W-1:0] prev_smp;
  logic [IDX_W-1:0] rise_idx;
  logic [CNT_W-1:0] peak_cnt;

  sample_item_t sample_q[$];
  peak_t        peak_report_q[$];
  sample_item_t tx_item;

  bit quiet;
  int tx_gap, rx_gap;
  int rx_hold_req, rx_hold_seen, rx_hold_left;
  int n_pushed, n_taken, n_results, n_peaks, n_buffers, n_settings, fail_cnt;
  int idle_cyc;

  // Predict the result of one sample; updates region state
  function void detect_peak(input logic [SMP_W-1:0] s, input logic is_last,
                            output bit has_res, output peak_t res);
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] width;
    logic [MAXP_W-1:0] cap;
    bit               emit;
    logic [IDX_W-1:0] pos;
    idx  = smp_idx;
    cap  = (maxp_reg == '0) ? MAXP_W'(1) : maxp_reg;
    emit = 1'b0;
    pos  = '0;
    if (!in_reg) begin
      if (s > thr_reg) begin
        in_reg    = 1'b1;
        reg_start = idx;
        if (s > prev_smp) rise_idx = idx;
      end
    end else if (s < thr_reg) begin
      width  = idx - reg_start;
      in_reg = 1'b0;
      if (width > minw_reg && peak_cnt < cap) begin
        emit     = 1'b1;
        pos      = rise_idx;
        peak_cnt = peak_cnt + CNT_W'(1);
      end
    end else if (s > prev_smp) begin
      rise_idx = idx;
    end
    prev_smp = s;
    smp_idx  = idx + IDX_W'(1);

    has_res           = emit || is_last;
    res.peak_valid    = emit;
    res.peak_position = POS_W'(pos);
    res.peak_count    = peak_cnt;
    res.buffer_done   = is_last;

    // buffer end clears region state, config is kept
    if (is_last) begin
      in_reg    = 1'b0;
      smp_idx   = '0;
      reg_start = '0;
      prev_smp  = '0;
      rise_idx  = '0;
      peak_cnt  = '0;
    end
  endfunction

  // Sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit    has_res;
    peak_t res;
    if (!rst_ni) begin
      smp_if.valid       <= 1'b0;
      smp_if.sample      <= '0;
      smp_if.last_sample <= 1'b0;
      tx_gap = 0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        detect_peak(smp_if.sample, smp_if.last_sample, has_res, res);
        if (has_res) peak_report_q.push_back(res);
        n_taken++;
      end
      if (!smp_if.valid || smp_if.ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          smp_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          tx_gap = $urandom_range(0, 15);
          smp_if.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          tx_item = sample_q.pop_front();
          smp_if.valid       <= 1'b1;
          smp_if.sample      <= tx_item.value;
          smp_if.last_sample <= tx_item.is_last;
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    peak_t got, want;
    if (!rst_ni) begin
      pk_if.ready <= 1'b0;
      rx_gap = 0;
      rx_hold_left = 0;
    end else begin
      if (pk_if.valid && pk_if.ready) begin
        got.peak_valid    = pk_if.peak_valid;
        got.peak_position = pk_if.peak_position;
        got.peak_count    = pk_if.peak_count;
        got.buffer_done   = pk_if.buffer_done;
        if (peak_report_q.size() == 0) begin
          $display("%0t: unexpected result: valid=%0b pos=%0d cnt=%0d done=%0b", $time,
                   got.peak_valid, got.peak_position, got.peak_count, got.buffer_done);
          fail_cnt++;
        end else begin
          want = peak_report_q.pop_front();
          n_results++;
          if (want.peak_valid)  n_peaks++;
          if (want.buffer_done) n_buffers++;
          if (got !== want) begin
            $display("%0t: result mismatch: expected valid=%0b pos=%0d cnt=%0d done=%0b",
                     $time, want.peak_valid, want.peak_position, want.peak_count,
                     want.buffer_done);
            $display("%0t:                  actual valid=%0b pos=%0d cnt=%0d done=%0b",
                     $time, got.peak_valid, got.peak_position, got.peak_count,
                     got.buffer_done);
            fail_cnt++;
          end
        end
      end
      if (rx_hold_seen != rx_hold_req) begin
        rx_hold_seen = rx_hold_req;
        rx_hold_left = HOLD_CYC;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        pk_if.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        pk_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 15);
        pk_if.ready <= 1'b0;
      end else begin
        pk_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((smp_if.valid && smp_if.ready) || (pk_if.valid && pk_if.ready) || cfg_we_i) begin
        idle_cyc = 0;
      end else begin
        idle_cyc++;
      end
      if (idle_cyc >= STALL_MAX) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cyc);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic [SMP_W-1:0] s, input logic is_last);
    sample_item_t it;
    it.value   = s;
    it.is_last = is_last;
    sample_q.push_back(it);
    n_pushed++;
  endtask

  function automatic logic [SMP_W-1:0] above_level();
    if (thr_reg == SMP_MAX) return SMP_W'(SMP_MAX);
    return SMP_W'($urandom_range(thr_reg + 1, SMP_MAX));
  endfunction

  function automatic logic [SMP_W-1:0] below_level();
    if (thr_reg == 0) return '0;
    return SMP_W'($urandom_range(0, thr_reg - 1));
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_THRESHOLD: thr_reg  = data[THRESH_W-1:0];
      CFG_MIN_WIDTH: minw_reg = data[MINW_W-1:0];
      CFG_MAX_PEAKS: maxp_reg = data[MAXP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [THRESH_W-1:0] thr, input logic [MINW_W-1:0] minw,
                               input logic [MAXP_W-1:0] maxp);
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_MIN_WIDTH, CFG_DATA_W'(minw));
    write_reg(CFG_MAX_PEAKS, CFG_DATA_W'(maxp));
    n_settings++;
  endtask

  // Wait for every sample taken and every result seen, then cover the pipeline
  task automatic wait_idle();
    while (n_taken != n_pushed || peak_report_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // One buffer of regions with random lengths up to the width limit plus 4, the limit taken as at most 16
  task automatic gen_buffer(input int n_regions);
    int len, lim, tail;
    lim = (minw_reg > 16) ? 16 : int'(minw_reg);
    for (int r = 0; r < n_regions; r++) begin
      repeat ($urandom_range(1, 3)) push_sample(below_level(), 1'b0);
      len = $urandom_range(1, lim + 4);
      push_sample(above_level(), 1'b0);
      for (int k = 1; k < len; k++) begin
        if ($urandom_range(0, 5) == 0) push_sample(thr_reg, 1'b0);
        else push_sample(above_level(), 1'b0);
      end
    end
    tail = $urandom_range(0, 2);
    if (tail == 0) push_sample(above_level(), 1'b1);
    else if (tail == 1) push_sample(below_level(), 1'b1);
    else push_sample(SMP_W'($urandom_range(0, SMP_MAX)), 1'b1);
  endtask

  task automatic run_random(input int n_items);
    int start;
    start = n_pushed;
    while (n_pushed - start < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        gen_buffer($urandom_range(1, 4));
      end else begin
        repeat ($urandom_range(1, 6))
          push_sample(SMP_W'($urandom_range(0, SMP_MAX)), $urandom_range(0, 15) == 0);
      end
    end
    wait_idle();
  endtask

  task automatic random_setting();
    logic [THRESH_W-1:0] thr;
    logic [MINW_W-1:0]   minw;
    logic [MAXP_W-1:0]   maxp;
    case ($urandom_range(0, 5))
      0:       thr = '0;
      1:       thr = THRESH_W'(SMP_MAX);
      2:       thr = THRESH_W'($urandom_range(1, 15));
      3:       thr = THRESH_W'($urandom_range(SMP_MAX - 15, SMP_MAX - 1));
      default: thr = THRESH_W'($urandom_range(0, SMP_MAX));
    endcase
    case ($urandom_range(0, 4))
      0:       minw = '0;
      1:       minw = '1;
      default: minw = MINW_W'($urandom_range(0, 12));
    endcase
    case ($urandom_range(0, 4))
      0:       maxp = '0;
      1:       maxp = 8'd1;
      2:       maxp = 8'd255;
      default: maxp = MAXP_W'($urandom_range(1, 4));
    endcase
    apply_setting(thr, minw, maxp);
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_THRESHOLD;
    cfg_data_i         = '0;
    smp_if.valid       = 1'b0;
    smp_if.sample      = '0;
    smp_if.last_sample = 1'b0;
    pk_if.ready        = 1'b0;
    thr_reg   = '0;
    minw_reg  = MIN_WIDTH_RST;
    maxp_reg  = MAX_PEAKS_RST;
    in_reg    = 1'b0;
    smp_idx   = '0;
    reg_start = '0;
    prev_smp  = '0;
    rise_idx  = '0;
    peak_cnt  = '0;
    quiet = 1'b0;
    rx_hold_req = 0; rx_hold_seen = 0;
    n_pushed = 0; n_taken = 0; n_results = 0; n_peaks = 0;
    n_buffers = 0; n_settings = 0; fail_cnt = 0; idle_cyc = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: rise at index 0, equal-to-threshold samples, narrow region,
    // last sample closing a region, capacity reached, region open at the end,
    // done without any peak
    apply_setting(20'h80000, 16'd2, 8'd2);
    push_sample(20'hFFFFF, 1'b0); push_sample(20'h80000, 1'b0); push_sample(20'h90000, 1'b0);
    push_sample(20'h7FFFF, 1'b0);
    push_sample(20'hFFFFF, 1'b0); push_sample(20'hFFFFF, 1'b0); push_sample(20'h00000, 1'b0);
    push_sample(20'hA0000, 1'b0); push_sample(20'hB0000, 1'b0); push_sample(20'hC0000, 1'b0);
    push_sample(20'h00000, 1'b1);
    push_sample(20'h80001, 1'b0); push_sample(20'h90000, 1'b0); push_sample(20'h90000, 1'b0);
    push_sample(20'h00000, 1'b0);
    push_sample(20'hC0000, 1'b0); push_sample(20'hC0000, 1'b0); push_sample(20'hC0000, 1'b0);
    push_sample(20'h7FFFF, 1'b0);
    push_sample(20'hD0000, 1'b0); push_sample(20'hD0000, 1'b0); push_sample(20'hD0000, 1'b0);
    push_sample(20'h00000, 1'b0);
    push_sample(20'hFFFFF, 1'b0); push_sample(20'hFFFFF, 1'b1);
    push_sample(20'h00000, 1'b1);
    wait_idle();

    // Threshold and width extremes, then zero capacity
    apply_setting('0, '0, 8'd255);
    run_random(60);
    apply_setting(THRESH_W'(SMP_MAX), '1, 8'd1);
    run_random(40);
    apply_setting(THRESH_W'($urandom_range(0, SMP_MAX)), '0, '0);
    run_random(100);

    // Random settings, one phase without idling
    for (int p = 0; p < 5; p++) begin
      random_setting();
      quiet = (p == 2);
      run_random(80);
    end
    quiet = 1'b0;

    // Receiver holds off while buffer ends keep arriving
    random_setting();
    quiet = 1'b1;
    rx_hold_req++;
    repeat (40) push_sample(SMP_W'($urandom_range(0, SMP_MAX)), 1'b1);
    wait_idle();

    // Final stretch with no idling on either side
    random_setting();
    run_random(100);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d sample transactions and %0d results (%0d peaks, %0d buffer ends)",
             n_taken, n_results, n_peaks, n_buffers);
    $display("over %0d register settings, with a long stall of the output side.",
             n_settings);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/trpd_pkg.sv
rtl/trpd_sample_if.sv
rtl/trpd_peak_if.sv
rtl/threshold_region_peak_detector_top.sv
tb/threshold_region_peak_detector_top_tb.sv
